/* hdl/sgdlr_pkg.sv */
package sgdlr_pkg;

    localparam int LANES     = 8;
    localparam int IN_LANES  = 8;
    localparam int FRAC_BITS = 16;
    localparam int RATE_BITS = 16;
    localparam int DW        = 32;
    localparam int CNT_W     = 4;
    localparam int LANE_IDX_W = $clog2(LANES + 1);

    localparam int TDATA_BITS = 2 + DW * IN_LANES + DW;
    localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;
    localparam int MDATA_BITS = DW + DW + 1;
    localparam int MDATA_W    = ((MDATA_BITS + 7) / 8) * 8;

    localparam logic [1:0] MODE_PREDICT = 2'd0;
    localparam logic [1:0] MODE_TRAIN   = 2'd1;
    localparam logic [1:0] MODE_LOAD    = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [1:0] REG_RATE      = 2'd0;
    localparam logic [1:0] REG_INTERCEPT = 2'd1;
    localparam logic [1:0] REG_COUNT     = 2'd2;

    localparam logic [15:0] RATE_RESET  = 16'd655;
    localparam logic [3:0]  COUNT_RESET = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_SUM,
        ST_ERR,
        ST_SCALE,
        ST_MUL,
        ST_UPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic prod_en;
        logic mul_le;
        logic upd_en;
        logic load_en;
    } lane_ctl_t;

    function automatic logic signed [DW-1:0] sat32(input logic signed [DW+8:0] v);
        logic signed [DW+8:0] mx;
        logic signed [DW+8:0] mn;
        mx = (DW+9)'(signed'({1'b0, {(DW-1){1'b1}}}));
        mn = (DW+9)'(signed'({1'b1, {(DW-1){1'b0}}}));
        if (v > mx) begin
            return {1'b0, {(DW-1){1'b1}}};
        end else if (v < mn) begin
            return {1'b1, {(DW-1){1'b0}}};
        end
        return v[DW-1:0];
    endfunction

endpackage

/* hdl/sgdlr_lane.sv */
module sgdlr_lane (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sgdlr_pkg::lane_ctl_t                  ctl,
    input  logic                                  active,
    input  logic signed [sgdlr_pkg::DW-1:0]       x,
    input  logic signed [sgdlr_pkg::DW-1:0]       load_val,
    input  logic signed [sgdlr_pkg::DW-1:0]       le,
    output logic signed [sgdlr_pkg::DW+sgdlr_pkg::DW-sgdlr_pkg::FRAC_BITS-1:0] term
);
    import sgdlr_pkg::*;

    localparam int TW = 2 * DW - FRAC_BITS;

    logic signed [DW-1:0]   w_reg, w_next;
    logic signed [2*DW-1:0] prod_reg, prod_next;
    logic signed [2*DW-1:0] mul_a;
    logic signed [TW:0]     wsum;
    logic signed [DW-1:0]   wsat;

    always_comb begin
        mul_a     = (ctl.mul_le ? le : w_reg) * x;
        prod_next = ctl.prod_en ? (active ? mul_a : '0) : prod_reg;
        wsum      = (TW+1)'(w_reg) - (TW+1)'(prod_reg >>> FRAC_BITS);
        if (wsum > (TW+1)'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
            wsat = {1'b0, {(DW-1){1'b1}}};
        end else if (wsum < (TW+1)'(signed'({1'b1, {(DW-1){1'b0}}}))) begin
            wsat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            wsat = wsum[DW-1:0];
        end
        w_next    = w_reg;
        if (ctl.load_en) begin
            w_next = load_val;
        end else if (ctl.upd_en && active) begin
            w_next = wsat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= '0;
        end else begin
            w_reg <= w_next;
        end
        prod_reg <= prod_next;
    end

    assign term = TW'(prod_reg >>> FRAC_BITS);

endmodule

/* hdl/sgdlr_merge.sv */
module sgdlr_merge (
    input  logic                                   aclk,
    input  logic signed [sgdlr_pkg::DW-1:0]        bias,
    input  logic signed [sgdlr_pkg::LANES-1:0][2*sgdlr_pkg::DW-sgdlr_pkg::FRAC_BITS-1:0] terms,
    output logic signed [sgdlr_pkg::DW-1:0]        pred
);
    import sgdlr_pkg::*;

    localparam int TW = 2 * DW - FRAC_BITS;
    localparam int SW = TW + LANE_IDX_W + 1;

    logic signed [SW-1:0] acc;
    logic signed [DW-1:0] pred_reg;

    always_comb begin
        acc = SW'(bias);
        for (int i = 0; i < LANES; i++) begin
            acc = acc + SW'(signed'(terms[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (acc > SW'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
            pred_reg <= {1'b0, {(DW-1){1'b1}}};
        end else if (acc < SW'(signed'({1'b1, {(DW-1){1'b0}}}))) begin
            pred_reg <= {1'b1, {(DW-1){1'b0}}};
        end else begin
            pred_reg <= acc[DW-1:0];
        end
    end

    assign pred = pred_reg;

endmodule

/* hdl/sgd_linear_regressor_core.sv */
// sequence: predict runs PROD, SUM, ERR, OUT; train adds SCALE, MUL, UPD; load, not-ready and unused answer from PROD
// throughput: one request at a time; the next is taken once the result leaves the output register
// the weight update reads the dot product of the same request, which sets the sequence length
// reset (aresetn low, synchronous): weights and bias zero, model not loaded, registers to defaults
module sgd_linear_regressor_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // mode, feature_0 .. feature_7, target
    input  logic [sgdlr_pkg::TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // prediction, error, status
    output logic [sgdlr_pkg::MDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [31:0]                       cfg_data
);
    import sgdlr_pkg::*;

    localparam int TW = 2 * DW - FRAC_BITS;

    state_t state_reg, state_next;
    logic [15:0]          rate_reg;
    logic                 icpt_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 loaded_reg, loaded_next;
    logic signed [DW-1:0] bias_reg, bias_next;
    logic [1:0]           mode_reg;
    logic signed [DW-1:0] x_reg [IN_LANES];
    logic signed [DW-1:0] tgt_reg;
    logic signed [DW-1:0] err_reg, err_next;
    logic signed [DW-1:0] le_reg, le_next;
    logic signed [DW-1:0] pred_w;
    logic                 mvalid_reg, mvalid_next;
    logic signed [DW-1:0] opred_reg, opred_next, oerr_reg, oerr_next;
    logic                 ostat_reg, ostat_next;
    logic signed [LANES-1:0][TW-1:0] terms;
    lane_ctl_t            ctl;
    logic signed [48:0]   rate_prod;
    logic signed [DW+8:0] diff;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !mvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= RATE_RESET;
            icpt_reg  <= 1'b1;
            count_reg <= COUNT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RATE:      rate_reg  <= cfg_data[15:0];
                REG_INTERCEPT: icpt_reg  <= cfg_data[0];
                REG_COUNT:     count_reg <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg <= s_tdata[1:0];
            for (int i = 0; i < IN_LANES; i++) begin
                x_reg[i] <= s_tdata[2+DW*i +: DW];
            end
            tgt_reg <= s_tdata[2+DW*IN_LANES +: DW];
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            logic lane_act;
            logic signed [DW-1:0] lx;
            assign lane_act = (CNT_W+1)'(g) < (CNT_W+1)'(count_reg);
            assign lx = (g < IN_LANES) ? x_reg[g] : '0;
            sgdlr_lane u_lane (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .active   (lane_act),
                .x        (lx),
                .load_val (lx),
                .le       (le_reg),
                .term     (terms[g])
            );
        end
    endgenerate

    sgdlr_merge u_merge (
        .aclk  (aclk),
        .bias  (bias_reg),
        .terms (terms),
        .pred  (pred_w)
    );

    always_comb begin
        state_next  = state_reg;
        ctl         = '0;
        loaded_next = loaded_reg;
        bias_next   = bias_reg;
        err_next    = err_reg;
        le_next     = le_reg;
        mvalid_next = mvalid_reg && !m_tready;
        opred_next  = opred_reg;
        oerr_next   = oerr_reg;
        ostat_next  = ostat_reg;
        diff        = (DW+9)'(pred_w) - (DW+9)'(tgt_reg);
        rate_prod   = signed'({1'b0, rate_reg}) * err_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                if ((mode_reg == MODE_PREDICT || mode_reg == MODE_TRAIN) && loaded_reg) begin
                    ctl.prod_en = 1'b1;
                    state_next  = ST_SUM;
                end else begin
                    if (mode_reg == MODE_LOAD) begin
                        ctl.load_en = 1'b1;
                        bias_next   = tgt_reg;
                        loaded_next = 1'b1;
                    end
                    opred_next  = '0;
                    oerr_next   = '0;
                    ostat_next  = (mode_reg != MODE_LOAD) && (mode_reg != MODE_UNUSED);
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_SUM: state_next = ST_ERR;
            ST_ERR: begin
                err_next   = sat32(diff);
                opred_next = pred_w;
                state_next = (mode_reg == MODE_TRAIN) ? ST_SCALE : ST_OUT;
            end
            ST_SCALE: begin
                le_next    = DW'(rate_prod >>> RATE_BITS);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                ctl.prod_en = 1'b1;
                ctl.mul_le  = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                ctl.upd_en = 1'b1;
                if (icpt_reg) begin
                    bias_next = sat32((DW+9)'(bias_reg) - (DW+9)'(le_reg));
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                oerr_next   = (mode_reg == MODE_TRAIN) ? err_reg : '0;
                ostat_next  = 1'b0;
                mvalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            loaded_reg <= 1'b0;
            bias_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            bias_reg   <= bias_next;
            mvalid_reg <= mvalid_next;
        end
        err_reg   <= err_next;
        le_reg    <= le_next;
        opred_reg <= opred_next;
        oerr_reg  <= oerr_next;
        ostat_reg <= ostat_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = MDATA_W'({ostat_reg, oerr_reg, opred_reg});

endmodule

/* tb/sgdlr_checker.sv */
module sgdlr_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sgdlr_pkg::TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sgdlr_pkg::MDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sgdlr_pkg::*;

    typedef struct packed {
        logic        status;
        logic [31:0] err;
        logic [31:0] pred;
    } outcome_t;

    logic signed [31:0] model_w [LANES];
    logic signed [31:0] model_bias;
    logic               model_loaded;
    logic [15:0]        rate;
    logic               icpt_en;
    logic [3:0]         lane_cnt;
    outcome_t           outcome_q[$];

    assign pending = outcome_q.size();

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic outcome_t lms_step(input logic [TDATA_W-1:0] d);
        outcome_t           o;
        logic [1:0]         mode;
        logic signed [31:0] x [IN_LANES];
        logic signed [31:0] tgt;
        logic signed [127:0] acc;
        logic signed [127:0] le;
        logic signed [31:0] p;
        logic signed [31:0] e;
        int                 n;
        mode = d[1:0];
        for (int i = 0; i < IN_LANES; i++) x[i] = d[2 + 32*i +: 32];
        tgt = d[2 + 32*IN_LANES +: 32];
        o = '0;
        if (mode == MODE_LOAD) begin
            for (int i = 0; i < LANES; i++) model_w[i] = x[i];
            model_bias = tgt;
            model_loaded = 1'b1;
        end else if (mode == MODE_PREDICT || mode == MODE_TRAIN) begin
            if (!model_loaded) begin
                o.status = 1'b1;
            end else begin
                n = (lane_cnt > LANES) ? LANES : lane_cnt;
                acc = model_bias;
                for (int i = 0; i < n; i++)
                    acc += (128'(x[i]) * 128'(model_w[i])) >>> FRAC_BITS;
                p = clamp32(acc);
                o.pred = p;
                if (mode == MODE_TRAIN) begin
                    e = clamp32(128'(p) - 128'(tgt));
                    o.err = e;
                    le = (128'(signed'({1'b0, rate})) * 128'(e)) >>> RATE_BITS;
                    for (int i = 0; i < n; i++)
                        model_w[i] = clamp32(128'(model_w[i])
                                             - ((le * 128'(x[i])) >>> FRAC_BITS));
                    if (icpt_en) model_bias = clamp32(128'(model_bias) - le);
                end
            end
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) model_w[i] = '0;
            model_bias   = '0;
            model_loaded = 1'b0;
            rate         = RATE_RESET;
            icpt_en      = 1'b1;
            lane_cnt     = COUNT_RESET;
            fail_count   = 0;
            outcome_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RATE:      rate = cfg_data[15:0];
                    REG_INTERCEPT: icpt_en = cfg_data[0];
                    REG_COUNT:     lane_cnt = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[64:0];
                if (outcome_q.size() == 0) begin
                    $error("result with no request pending: %h", got);
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got.pred !== want.pred) begin
                        $error("prediction expected %h actual %h", want.pred, got.pred);
                        fail_count++;
                    end
                    if (got.err !== want.err) begin
                        $error("error expected %h actual %h", want.err, got.err);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status expected %h actual %h", want.status, got.status);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) outcome_q.push_back(lms_step(s_tdata));
        end
    end
endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sgdlr_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [MDATA_W-1:0] m_tdata;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 pending;
    bit                 hold_off;

    sgd_linear_regressor_core DUT (.*);

    sgdlr_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("sgd_linear_regressor_core: mismatch");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            3, 4, 5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(input logic [1:0] mode, input logic [31:0] x [8],
                                input logic [31:0] tgt);
        logic [TDATA_W-1:0] d;
        int gap;
        d = '0;
        d[1:0] = mode;
        for (int i = 0; i < IN_LANES; i++) d[2 + 32*i +: 32] = x[i];
        d[2 + 32*IN_LANES +: 32] = tgt;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic rand_request(input logic [1:0] mode);
        logic [31:0] x [8];
        for (int i = 0; i < 8; i++) x[i] = rand_val();
        send_request(mode, x, rand_val());
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (gap_len() > 0) begin
                m_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge aclk);
            end
        end
    end

    initial begin
        logic [31:0] x [8];
        logic [31:0] zx [8];
        int wait_cnt;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_RATE;
        cfg_data  <= '0;
        hold_off  = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // not ready, unused mode, then first load, predict and train
        for (int i = 0; i < 8; i++) begin
            x[i] = 32'h00010000 * (i + 1);
            zx[i] = '0;
        end
        send_request(MODE_PREDICT, x, 32'h00020000);
        send_request(MODE_TRAIN, x, 32'h00020000);
        send_request(MODE_UNUSED, x, 32'h00020000);
        send_request(MODE_LOAD, x, 32'h00008000);
        send_request(MODE_PREDICT, x, 32'h0);
        send_request(MODE_TRAIN, x, 32'h00050000);
        send_request(MODE_UNUSED, x, 32'h7fffffff);
        // saturation extremes, then a zero model
        for (int i = 0; i < 8; i++) x[i] = 32'h7fffffff;
        send_request(MODE_LOAD, x, 32'h7fffffff);
        send_request(MODE_PREDICT, x, 32'h0);
        send_request(MODE_TRAIN, x, 32'h80000000);
        for (int i = 0; i < 8; i++) x[i] = 32'h80000000;
        send_request(MODE_TRAIN, x, 32'h7fffffff);
        send_request(MODE_PREDICT, x, 32'h80000000);
        send_request(MODE_LOAD, zx, 32'h0);
        send_request(MODE_TRAIN, zx, 32'hffffffff);

        write_reg(REG_RATE, 32'hffff);
        write_reg(REG_INTERCEPT, 32'h0);
        write_reg(REG_COUNT, 32'h0);
        rand_request(MODE_LOAD);
        rand_request(MODE_TRAIN);
        rand_request(MODE_PREDICT);
        write_reg(REG_COUNT, 32'hf);
        rand_request(MODE_TRAIN);
        rand_request(MODE_PREDICT);

        // output held off while requests keep coming
        hold_off = 1'b1;
        for (int i = 0; i < 20; i++) rand_request(MODE_PREDICT);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_reg(REG_RATE, 32'h0);
                1: write_reg(REG_RATE, 32'd655);
                2: write_reg(REG_RATE, $urandom_range(0, 65535));
                3: write_reg(REG_COUNT, 32'd1);
                4: write_reg(REG_INTERCEPT, 32'h1);
                5: write_reg(REG_COUNT, $urandom_range(0, 15));
                6: write_reg(REG_RATE, 32'hffff);
                default: write_reg(REG_COUNT, 32'd8);
            endcase
            rand_request(MODE_LOAD);
            for (int k = 0; k < 140; k++) begin
                case ($urandom_range(0, 19))
                    0: rand_request(MODE_LOAD);
                    1: rand_request(MODE_UNUSED);
                    2, 3, 4, 5, 6: rand_request(MODE_PREDICT);
                    default: rand_request(MODE_TRAIN);
                endcase
            end
        end

        s_tvalid <= 1'b0;
        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (20) @(posedge aclk);
        if (pending == 0 && fail_count == 0)
            $display("sgd_linear_regressor_core: match");
        else
            $display("sgd_linear_regressor_core: mismatch");
        $finish;
    end
endmodule

/* sim.f */
hdl/sgdlr_pkg.sv
hdl/sgdlr_lane.sv
hdl/sgdlr_merge.sv
hdl/sgd_linear_regressor_core.sv
tb/sgdlr_checker.sv
tb/tb_top.sv
